### hw/rtl/assert_macros.svh
// assertion helpers, sampled on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

### hw/rtl/satalru_pkg.sv
package satalru_pkg;

  localparam int SETS_DEFAULT = 16;
  localparam int WAYS_DEFAULT = 4;
  localparam int BLOCK_BITS_DEFAULT = 30;
  localparam int TIME_BITS_DEFAULT = 32;

  localparam logic [2:0] CMD_PROBE = 3'd0;
  localparam logic [2:0] CMD_RD_HIT = 3'd1;
  localparam logic [2:0] CMD_WR_HIT = 3'd2;
  localparam logic [2:0] CMD_ALLOC = 3'd3;
  localparam logic [2:0] CMD_INV_BLK = 3'd4;
  localparam logic [2:0] CMD_FLUSH = 3'd5;
  localparam logic [2:0] CMD_INV_ALL = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FL_RD,
    ST_FL_CHK,
    ST_FL_END
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic fl_chk;
    logic fl_end;
  } ctl_t;

  typedef struct packed {
    logic is_flush;
    logic scan_last;
    logic stop;
  } sts_t;

endpackage

### hw/rtl/set_assoc_tag_array_lru_unit.sv
// Write-back set-associative tag array with least-recently-accessed replacement.
// An item is taken when start is high and busy is low. Every command but flush
// does a tag and time read, then a compare and update, giving one registered
// result; the next item may be taken right after. Flush starts, walks all
// SETS*WAYS lines with a read and a check step each and closes with an end step,
// giving one result per written-back line, or one without writeback if none;
// it stops at the first dirty line that finds no queue room. Results appear for
// one cycle with done high and cannot be held off. SETS must be a power of two.
`include "assert_macros.svh"

module set_assoc_tag_array_lru_unit #(
  parameter int SETS = satalru_pkg::SETS_DEFAULT,
  parameter int WAYS = satalru_pkg::WAYS_DEFAULT,
  parameter int BLOCK_BITS = satalru_pkg::BLOCK_BITS_DEFAULT,
  parameter int TIME_BITS = satalru_pkg::TIME_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [29:0] block_index,
  input  logic [1:0]  hit_way,
  input  logic [31:0] now,
  input  logic [6:0]  queue_room,
  output logic        done,
  output logic        hit,
  output logic [1:0]  way,
  output logic        ok,
  output logic        writeback_valid,
  output logic [31:0] writeback_address,
  output logic        last
);

  satalru_pkg::ctl_t ctl;
  satalru_pkg::sts_t sts;

  satalru_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  satalru_dp #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .BLOCK_BITS (BLOCK_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .sts               (sts),
    .command           (command),
    .block_index       (block_index),
    .hit_way           (hit_way),
    .now               (now),
    .queue_room        (queue_room),
    .done              (done),
    .hit               (hit),
    .way               (way),
    .ok                (ok),
    .writeback_valid   (writeback_valid),
    .writeback_address (writeback_address),
    .last              (last)
  );

  `ASSERT_NEXT(a_take_busy, start && !busy, busy)
  `ASSERT_IMPLY(a_nonlast_wb, done && !last, writeback_valid && ok)
  `ASSERT_IMPLY(a_addr_zero, done && !writeback_valid, writeback_address == 32'd0)

endmodule

### hw/rtl/satalru_ctrl.sv
module satalru_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  satalru_pkg::sts_t sts,
  output satalru_pkg::ctl_t ctl,
  output logic              busy
);

  satalru_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= satalru_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      satalru_pkg::ST_IDLE: begin
        if (start) state_next = satalru_pkg::ST_EXEC;
      end
      satalru_pkg::ST_EXEC: begin
        state_next = sts.is_flush ? satalru_pkg::ST_FL_RD : satalru_pkg::ST_IDLE;
      end
      satalru_pkg::ST_FL_RD: state_next = satalru_pkg::ST_FL_CHK;
      satalru_pkg::ST_FL_CHK: begin
        if (sts.stop) state_next = satalru_pkg::ST_IDLE;
        else if (sts.scan_last) state_next = satalru_pkg::ST_FL_END;
        else state_next = satalru_pkg::ST_FL_RD;
      end
      satalru_pkg::ST_FL_END: state_next = satalru_pkg::ST_IDLE;
      default: state_next = satalru_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    busy = 1'b1;
    case (state)
      satalru_pkg::ST_IDLE: begin
        busy = 1'b0;
        ctl.capture = start;
      end
      satalru_pkg::ST_EXEC: ctl.exec = 1'b1;
      satalru_pkg::ST_FL_RD: ctl = '0;
      satalru_pkg::ST_FL_CHK: ctl.fl_chk = 1'b1;
      satalru_pkg::ST_FL_END: ctl.fl_end = 1'b1;
      default: ctl = '0;
    endcase
  end

endmodule

### hw/rtl/satalru_dp.sv
module satalru_dp #(
  parameter int SETS = satalru_pkg::SETS_DEFAULT,
  parameter int WAYS = satalru_pkg::WAYS_DEFAULT,
  parameter int BLOCK_BITS = satalru_pkg::BLOCK_BITS_DEFAULT,
  parameter int TIME_BITS = satalru_pkg::TIME_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  satalru_pkg::ctl_t ctl,
  output satalru_pkg::sts_t sts,
  input  logic [2:0]        command,
  input  logic [29:0]       block_index,
  input  logic [1:0]        hit_way,
  input  logic [31:0]       now,
  input  logic [6:0]        queue_room,
  output logic              done,
  output logic              hit,
  output logic [1:0]        way,
  output logic              ok,
  output logic              writeback_valid,
  output logic [31:0]       writeback_address,
  output logic              last
);

  localparam int SET_LOG = $clog2(SETS);
  localparam int SET_W = (SETS > 1) ? SET_LOG : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W = BLOCK_BITS - SET_LOG;

  logic [BLOCK_BITS-1:0] in_blk;
  logic [SET_W-1:0]      in_set;
  logic [SET_W-1:0]      rd_set;

  logic [2:0]            c_cmd;
  logic [TAG_W-1:0]      c_tag;
  logic [SET_W-1:0]      c_set;
  logic [1:0]            c_hw;
  logic [TIME_BITS-1:0]  c_now;
  logic [6:0]            room;

  logic [SETS-1:0][WAYS-1:0] valid, valid_next, dirty, dirty_next;
  logic [TAG_W-1:0]     rd_tag [WAYS];
  logic [TIME_BITS-1:0] rd_time [WAYS];
  logic [WAYS-1:0]      wr_tag_en, wr_time_en;

  logic [SET_W-1:0] scan_set;
  logic [WAY_W-1:0] scan_way;
  logic             pend;
  logic [31:0]      pend_addr;

  logic             o_done, o_hit, o_ok, o_wbv, o_last;
  logic [1:0]       o_way;
  logic [31:0]      o_addr;
  logic             pend_next;
  logic [31:0]      pend_addr_next;
  logic [6:0]       room_next;

  logic [WAYS-1:0]  match;
  logic [WAY_W-1:0] hit_idx, vic, best, hw_i;
  logic             found_hit, found_inv, line, scan_last;
  logic [BLOCK_BITS-1:0] vic_blk, scan_blk;

  assign in_blk = BLOCK_BITS'(block_index);
  assign in_set = SET_W'(in_blk & BLOCK_BITS'(SETS - 1));
  assign rd_set = ctl.capture ? in_set : scan_set;
  assign hw_i = WAY_W'(c_hw);

  for (genvar g = 0; g < WAYS; g++) begin : g_way
    logic [TAG_W-1:0]     tag_mem [SETS];
    logic [TIME_BITS-1:0] time_mem [SETS];
    always_ff @(posedge clk) begin
      if (wr_tag_en[g]) tag_mem[c_set] <= c_tag;
      if (wr_time_en[g]) time_mem[c_set] <= c_now;
      rd_tag[g] <= tag_mem[rd_set];
      rd_time[g] <= time_mem[rd_set];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      c_cmd <= command;
      c_tag <= TAG_W'(in_blk >> SET_LOG);
      c_set <= in_set;
      c_hw <= hit_way;
      c_now <= TIME_BITS'(now);
    end
    room <= room_next;
    pend_addr <= pend_addr_next;
    hit <= o_hit;
    way <= o_way;
    ok <= o_ok;
    writeback_valid <= o_wbv;
    writeback_address <= o_addr;
    last <= o_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      dirty <= '0;
      done <= 1'b0;
      pend <= 1'b0;
      scan_set <= '0;
      scan_way <= '0;
    end else begin
      valid <= valid_next;
      dirty <= dirty_next;
      done <= o_done;
      pend <= pend_next;
      if (ctl.capture) begin
        scan_set <= '0;
        scan_way <= '0;
      end else if (ctl.fl_chk && !sts.stop) begin
        if (scan_way == WAY_W'(WAYS - 1)) begin
          scan_way <= '0;
          scan_set <= scan_set + 1'b1;
        end else begin
          scan_way <= scan_way + 1'b1;
        end
      end
    end
  end

  assign scan_last = (scan_set == SET_W'(SETS - 1)) && (scan_way == WAY_W'(WAYS - 1));
  assign line = valid[scan_set][scan_way] && dirty[scan_set][scan_way];
  assign sts.is_flush = (c_cmd == satalru_pkg::CMD_FLUSH);
  assign sts.scan_last = scan_last;
  assign sts.stop = line && (room == '0);

  always_comb begin
    found_hit = 1'b0;
    hit_idx = '0;
    found_inv = 1'b0;
    vic = '0;
    best = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = valid[c_set][w] && (rd_tag[w] == c_tag);
      if (!found_hit && match[w]) begin
        found_hit = 1'b1;
        hit_idx = WAY_W'(w);
      end
      if (!found_inv && !valid[c_set][w]) begin
        found_inv = 1'b1;
        vic = WAY_W'(w);
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (rd_time[w] < rd_time[best]) best = WAY_W'(w);
    end
    if (!found_inv) vic = best;
  end

  assign vic_blk = (BLOCK_BITS'(rd_tag[vic]) << SET_LOG) | BLOCK_BITS'(c_set);
  assign scan_blk = (BLOCK_BITS'(rd_tag[scan_way]) << SET_LOG) | BLOCK_BITS'(scan_set);

  always_comb begin
    valid_next = valid;
    dirty_next = dirty;
    wr_tag_en = '0;
    wr_time_en = '0;
    room_next = ctl.capture ? queue_room : room;
    pend_next = ctl.capture ? 1'b0 : pend;
    pend_addr_next = pend_addr;
    o_done = 1'b0;
    o_hit = 1'b0;
    o_way = '0;
    o_ok = 1'b1;
    o_wbv = 1'b0;
    o_addr = '0;
    o_last = 1'b1;
    if (ctl.exec) begin
      o_done = 1'b1;
      case (c_cmd)
        satalru_pkg::CMD_PROBE: begin
          o_hit = found_hit;
          o_way = found_hit ? 2'(hit_idx) : 2'd0;
        end
        satalru_pkg::CMD_RD_HIT, satalru_pkg::CMD_WR_HIT: begin
          if ((32'(c_hw) >= 32'(WAYS)) || !valid[c_set][hw_i]) begin
            o_ok = 1'b0;
          end else begin
            wr_time_en[hw_i] = 1'b1;
            if (c_cmd == satalru_pkg::CMD_WR_HIT) dirty_next[c_set][hw_i] = 1'b1;
          end
        end
        satalru_pkg::CMD_ALLOC: begin
          o_way = 2'(vic);
          if (valid[c_set][vic] && dirty[c_set][vic] && room == '0) begin
            o_ok = 1'b0;
          end else begin
            o_wbv = valid[c_set][vic] && dirty[c_set][vic];
            o_addr = o_wbv ? (32'(vic_blk) << 2) : 32'd0;
            valid_next[c_set][vic] = 1'b1;
            dirty_next[c_set][vic] = 1'b0;
            wr_tag_en[vic] = 1'b1;
            wr_time_en[vic] = 1'b1;
          end
        end
        satalru_pkg::CMD_INV_BLK: begin
          for (int w = 0; w < WAYS; w++) begin
            if (match[w]) begin
              valid_next[c_set][w] = 1'b0;
              dirty_next[c_set][w] = 1'b0;
            end
          end
        end
        satalru_pkg::CMD_FLUSH: o_done = 1'b0;
        satalru_pkg::CMD_INV_ALL: begin
          valid_next = '0;
          dirty_next = '0;
        end
        default: o_ok = 1'b0;
      endcase
    end else if (ctl.fl_chk && line) begin
      if (room == '0) begin
        o_done = 1'b1;
        o_ok = 1'b0;
        o_wbv = pend;
        o_addr = pend ? pend_addr : 32'd0;
        pend_next = 1'b0;
      end else begin
        if (pend) begin
          o_done = 1'b1;
          o_wbv = 1'b1;
          o_addr = pend_addr;
          o_last = 1'b0;
        end
        pend_next = 1'b1;
        pend_addr_next = 32'(scan_blk) << 2;
        dirty_next[scan_set][scan_way] = 1'b0;
        room_next = room - 1'b1;
      end
    end else if (ctl.fl_end) begin
      o_done = 1'b1;
      o_wbv = pend;
      o_addr = pend ? pend_addr : 32'd0;
      pend_next = 1'b0;
    end
  end

endmodule

### dv/set_assoc_tag_array_lru_checker.sv
module set_assoc_tag_array_lru_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  command,
  input  logic [29:0] block_index,
  input  logic [1:0]  hit_way,
  input  logic [31:0] now,
  input  logic [6:0]  queue_room,
  input  logic        done,
  input  logic        hit,
  input  logic [1:0]  way,
  input  logic        ok,
  input  logic        writeback_valid,
  input  logic [31:0] writeback_address,
  input  logic        last,
  output int          failures,
  output int          pending,
  output int          results_seen,
  output int          flush_writebacks
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSETS = satalru_pkg::SETS_DEFAULT;
  localparam int NWAYS = satalru_pkg::WAYS_DEFAULT;

  typedef struct packed {
    logic        hit;
    logic [1:0]  way;
    logic        ok;
    logic        wb_valid;
    logic [31:0] wb_addr;
    logic        last;
  } tag_result_t;

  tag_result_t expected_results[$];

  logic        valid_bits[NSETS][NWAYS];
  logic        dirty_bits[NSETS][NWAYS];
  logic [25:0] tags[NSETS][NWAYS];
  logic [31:0] stamps[NSETS][NWAYS];

  function automatic tag_result_t mk(logic h, logic [1:0] w, logic k, logic v,
                                     logic [31:0] a, logic l);
    tag_result_t r;
    r.hit = h;
    r.way = w;
    r.ok = k;
    r.wb_valid = v;
    r.wb_addr = a;
    r.last = l;
    return r;
  endfunction

  function automatic logic [31:0] line_addr(int s, int w);
    return {tags[s][w], s[3:0], 2'b00};
  endfunction

  function automatic void queue_expected(tag_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  task automatic predict_command(logic [2:0] cmd, logic [29:0] blk, logic [1:0] hw,
                                 logic [31:0] stamp, logic [6:0] room_in);
    int s;
    int v;
    int n;
    int room;
    logic [25:0] t;
    logic found;
    tag_result_t r;
    s = int'(blk[3:0]);
    t = blk[29:4];
    room = int'(room_in);
    case (cmd)
      satalru_pkg::CMD_PROBE: begin
        found = 1'b0;
        for (int w = 0; w < NWAYS; w++) begin
          if (!found && valid_bits[s][w] && tags[s][w] == t) begin
            queue_expected(mk(1'b1, w[1:0], 1'b1, 1'b0, 32'd0, 1'b1));
            found = 1'b1;
          end
        end
        if (!found) queue_expected(mk(1'b0, 2'd0, 1'b1, 1'b0, 32'd0, 1'b1));
      end
      satalru_pkg::CMD_RD_HIT, satalru_pkg::CMD_WR_HIT: begin
        if (!valid_bits[s][hw]) begin
          queue_expected(mk(1'b0, 2'd0, 1'b0, 1'b0, 32'd0, 1'b1));
        end else begin
          stamps[s][hw] = stamp;
          if (cmd == satalru_pkg::CMD_WR_HIT) dirty_bits[s][hw] = 1'b1;
          queue_expected(mk(1'b0, 2'd0, 1'b1, 1'b0, 32'd0, 1'b1));
        end
      end
      satalru_pkg::CMD_ALLOC: begin
        v = -1;
        for (int w = 0; w < NWAYS; w++) begin
          if (v < 0 && !valid_bits[s][w]) v = w;
        end
        if (v < 0) begin
          v = 0;
          for (int w = 1; w < NWAYS; w++) begin
            if (stamps[s][w] < stamps[s][v]) v = w;
          end
        end
        if (valid_bits[s][v] && dirty_bits[s][v] && room == 0) begin
          queue_expected(mk(1'b0, v[1:0], 1'b0, 1'b0, 32'd0, 1'b1));
        end else begin
          if (valid_bits[s][v] && dirty_bits[s][v])
            r = mk(1'b0, v[1:0], 1'b1, 1'b1, line_addr(s, v), 1'b1);
          else r = mk(1'b0, v[1:0], 1'b1, 1'b0, 32'd0, 1'b1);
          valid_bits[s][v] = 1'b1;
          dirty_bits[s][v] = 1'b0;
          tags[s][v] = t;
          stamps[s][v] = stamp;
          queue_expected(r);
        end
      end
      satalru_pkg::CMD_INV_BLK: begin
        for (int w = 0; w < NWAYS; w++) begin
          if (valid_bits[s][w] && tags[s][w] == t) begin
            valid_bits[s][w] = 1'b0;
            dirty_bits[s][w] = 1'b0;
          end
        end
        queue_expected(mk(1'b0, 2'd0, 1'b1, 1'b0, 32'd0, 1'b1));
      end
      satalru_pkg::CMD_FLUSH: begin
        n = 0;
        found = 1'b0;
        for (int fs = 0; fs < NSETS; fs++) begin
          for (int w = 0; w < NWAYS; w++) begin
            if (!found && valid_bits[fs][w] && dirty_bits[fs][w]) begin
              if (room == 0) begin
                found = 1'b1;
              end else begin
                queue_expected(mk(1'b0, 2'd0, 1'b1, 1'b1, line_addr(fs, w), 1'b0));
                dirty_bits[fs][w] = 1'b0;
                room--;
                n++;
              end
            end
          end
        end
        flush_writebacks += n;
        if (n == 0) begin
          queue_expected(mk(1'b0, 2'd0, !found, 1'b0, 32'd0, 1'b1));
        end else begin
          r = expected_results.pop_back();
          r.last = 1'b1;
          if (found) r.ok = 1'b0;
          queue_expected(r);
        end
      end
      satalru_pkg::CMD_INV_ALL: begin
        for (int fs = 0; fs < NSETS; fs++) begin
          for (int w = 0; w < NWAYS; w++) begin
            valid_bits[fs][w] = 1'b0;
            dirty_bits[fs][w] = 1'b0;
          end
        end
        queue_expected(mk(1'b0, 2'd0, 1'b1, 1'b0, 32'd0, 1'b1));
      end
      default: queue_expected(mk(1'b0, 2'd0, 1'b0, 1'b0, 32'd0, 1'b1));
    endcase
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    failures++;
  endtask

  initial begin
    failures = 0;
    results_seen = 0;
    flush_writebacks = 0;
    pending = 0;
    for (int s = 0; s < NSETS; s++) begin
      for (int w = 0; w < NWAYS; w++) begin
        valid_bits[s][w] = 1'b0;
        dirty_bits[s][w] = 1'b0;
        tags[s][w] = '0;
        stamps[s][w] = '0;
      end
    end
  end

  always @(posedge clk) begin
    tag_result_t e;
    if (!rst) begin
      if (done) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 32'd0, 32'd0);
        end else begin
          e = expected_results.pop_front();
          if (hit !== e.hit) report_mismatch("hit", 32'(hit), 32'(e.hit));
          if (way !== e.way) report_mismatch("way", 32'(way), 32'(e.way));
          if (ok !== e.ok) report_mismatch("ok", 32'(ok), 32'(e.ok));
          if (writeback_valid !== e.wb_valid)
            report_mismatch("writeback_valid", 32'(writeback_valid), 32'(e.wb_valid));
          if (writeback_address !== e.wb_addr)
            report_mismatch("writeback_address", writeback_address, e.wb_addr);
          if (last !== e.last) report_mismatch("last", 32'(last), 32'(e.last));
        end
      end
      if (start && !busy) predict_command(command, block_index, hit_way, now, queue_room);
      pending = expected_results.size();
    end
  end
endmodule

### dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  command;
  logic [29:0] block_index;
  logic [1:0]  hit_way;
  logic [31:0] now;
  logic [6:0]  queue_room;
  logic        done;
  logic        hit;
  logic [1:0]  way;
  logic        ok;
  logic        writeback_valid;
  logic [31:0] writeback_address;
  logic        last;
  int          failures;
  int          pending;
  int          results_seen;
  int          flush_writebacks;
  int          cycles;
  int          items_sent;
  bit          idle_enable;
  logic [31:0] stamp;
  logic [29:0] addr_pool[16];

  localparam logic [2:0] CMD_UNKNOWN = 3'd7;
  localparam int CYCLE_LIMIT = 400000;

  set_assoc_tag_array_lru_unit DUT (.*);

  set_assoc_tag_array_lru_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("set_assoc_tag_array_lru_unit regression: fail");
        $finish;
      end
    end
  end

  task automatic send(logic [2:0] cmd, logic [29:0] blk, logic [1:0] hw,
                      logic [31:0] t, logic [6:0] room);
    @(negedge clk);
    if (idle_enable && $urandom_range(99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    block_index <= blk;
    hit_way <= hw;
    now <= t;
    queue_room <= room;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    items_sent++;
  endtask

  task automatic random_item();
    int pick;
    logic [2:0] cmd;
    logic [29:0] blk;
    logic [6:0] room;
    pick = $urandom_range(99);
    if (pick < 30) cmd = satalru_pkg::CMD_ALLOC;
    else if (pick < 45) cmd = satalru_pkg::CMD_PROBE;
    else if (pick < 60) cmd = satalru_pkg::CMD_RD_HIT;
    else if (pick < 80) cmd = satalru_pkg::CMD_WR_HIT;
    else if (pick < 88) cmd = satalru_pkg::CMD_INV_BLK;
    else if (pick < 95) cmd = satalru_pkg::CMD_FLUSH;
    else if (pick < 98) cmd = satalru_pkg::CMD_INV_ALL;
    else cmd = CMD_UNKNOWN;
    if ($urandom_range(9) == 0) blk = 30'($urandom);
    else blk = addr_pool[4'($urandom_range(15))];
    pick = $urandom_range(9);
    if (pick < 2) room = 7'd0;
    else if (pick < 5) room = 7'($urandom_range(3, 1));
    else room = 7'($urandom_range(64));
    pick = $urandom_range(9);
    if (pick == 0) stamp = $urandom;
    else if (pick > 2) stamp = stamp + $urandom_range(5, 1);
    send(cmd, blk, 2'($urandom), stamp, room);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    command = satalru_pkg::CMD_PROBE;
    block_index = '0;
    hit_way = '0;
    now = '0;
    queue_room = '0;
    items_sent = 0;
    idle_enable = 1'b1;
    stamp = 32'd100;
    for (int i = 0; i < 16; i++) begin
      addr_pool[i] = {2'($urandom_range(3)), 2'b00, 26'($urandom)};
      addr_pool[i] = {addr_pool[i][29:4], 2'b00, 2'($urandom_range(2))};
    end
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed
    send(satalru_pkg::CMD_PROBE, 30'd0, 2'd0, 32'd0, 7'd0);
    send(satalru_pkg::CMD_ALLOC, 30'd0, 2'd0, 32'd0, 7'd0);
    send(satalru_pkg::CMD_ALLOC, 30'h3fffffff, 2'd3, 32'hffffffff, 7'd64);
    send(satalru_pkg::CMD_PROBE, 30'd0, 2'd0, 32'd1, 7'd0);
    send(satalru_pkg::CMD_PROBE, 30'h3fffffff, 2'd0, 32'd1, 7'd0);
    send(satalru_pkg::CMD_RD_HIT, 30'd0, 2'd1, 32'd5, 7'd0);
    send(satalru_pkg::CMD_WR_HIT, 30'd0, 2'd0, 32'd6, 7'd0);
    send(satalru_pkg::CMD_ALLOC, 30'h10, 2'd0, 32'd7, 7'd0);
    send(satalru_pkg::CMD_ALLOC, 30'h20, 2'd0, 32'd8, 7'd0);
    send(satalru_pkg::CMD_ALLOC, 30'h30, 2'd0, 32'd8, 7'd0);
    send(satalru_pkg::CMD_WR_HIT, 30'h10, 2'd1, 32'd2, 7'd0);
    send(satalru_pkg::CMD_ALLOC, 30'h40, 2'd0, 32'd9, 7'd0);
    send(satalru_pkg::CMD_ALLOC, 30'h40, 2'd0, 32'd9, 7'd1);
    send(satalru_pkg::CMD_WR_HIT, 30'h20, 2'd2, 32'd10, 7'd0);
    send(satalru_pkg::CMD_WR_HIT, 30'h3fffffff, 2'd0, 32'd11, 7'd0);
    send(satalru_pkg::CMD_FLUSH, 30'd0, 2'd0, 32'd12, 7'd1);
    send(satalru_pkg::CMD_FLUSH, 30'd0, 2'd0, 32'd12, 7'd0);
    send(satalru_pkg::CMD_FLUSH, 30'd0, 2'd0, 32'd12, 7'd64);
    send(satalru_pkg::CMD_FLUSH, 30'd0, 2'd0, 32'd12, 7'd64);
    send(satalru_pkg::CMD_INV_BLK, 30'h20, 2'd0, 32'd13, 7'd0);
    send(satalru_pkg::CMD_PROBE, 30'h20, 2'd0, 32'd13, 7'd0);
    send(CMD_UNKNOWN, 30'h15555555, 2'd2, 32'h55555555, 7'd127);
    send(satalru_pkg::CMD_INV_ALL, 30'd0, 2'd0, 32'd14, 7'd0);
    send(satalru_pkg::CMD_RD_HIT, 30'h10, 2'd1, 32'd15, 7'd0);

    // random
    for (int i = 0; i < 206; i++) begin
      idle_enable = !(i >= 90 && i < 150);
      random_item();
    end
    @(negedge clk);
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("sent %0d items, checked %0d results", items_sent, results_seen);
    $display("flush wrote back %0d dirty lines", flush_writebacks);
    if (failures == 0 && pending == 0) begin
      $display("set_assoc_tag_array_lru_unit regression: pass");
    end else begin
      $display("set_assoc_tag_array_lru_unit regression: fail");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/satalru_pkg.sv
hw/rtl/satalru_ctrl.sv
hw/rtl/satalru_dp.sv
hw/rtl/set_assoc_tag_array_lru_unit.sv
dv/set_assoc_tag_array_lru_checker.sv
dv/testbench.sv
